>>> rtl/core/gtpu_hp_pkg.sv
`timescale 1ns / 1ps

package gtpu_hp_pkg;

    // Default width of the saturating header octet counter.
    localparam int COUNT_BITS_DEF = 16;

    // Width of the header_bytes result field.
    localparam int HDR_BYTES_W = 16;

    // Header constants.
    localparam logic [7:0] VER_PT   = 8'h30;
    localparam logic [7:0] OPT_MASK = 8'h07;
    localparam logic [7:0] EXT_CONT = 8'h85;
    localparam logic [7:0] EXT_END  = 8'h00;
    localparam logic [7:0] VER_MASK = 8'hf0;
    localparam logic [7:0] QFI_MASK = 8'h3f;

    // Positions within the fixed part of the header.
    localparam logic [3:0] FIX_FLAGS  = 4'd0;
    localparam logic [3:0] FIX_TYPE   = 4'd1;
    localparam logic [3:0] FIX_LEN_HI = 4'd2;
    localparam logic [3:0] FIX_LEN_LO = 4'd3;
    localparam logic [3:0] FIX_TEID0  = 4'd4;
    localparam logic [3:0] FIX_TEID1  = 4'd5;
    localparam logic [3:0] FIX_TEID2  = 4'd6;
    localparam logic [3:0] FIX_TEID3  = 4'd7;
    localparam logic [3:0] FIX_NEXT   = 4'd11;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADVER = 2'd1;
    localparam logic [1:0] ST_BADLEN = 2'd2;
    localparam logic [1:0] ST_TRUNC  = 2'd3;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_FIXED,
        PH_EXTLEN,
        PH_CONT1,
        PH_CONT2,
        PH_SKIP,
        PH_NEXT,
        PH_PAYLOAD
    } t_phase;

    // One packet octet.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One parsed header result.
    typedef struct packed {
        logic [7:0]             message_type;
        logic [15:0]            length_field;
        logic [31:0]            tunnel_id;
        logic                   container_present;
        logic [3:0]             pdu_type;
        logic [5:0]             flow_id;
        logic [HDR_BYTES_W-1:0] header_bytes;
        logic [1:0]             status;
    } t_out_item;

endpackage

>>> rtl/core/gtpu_hp_in_reg.sv
`timescale 1ns / 1ps

module gtpu_hp_in_reg
    import gtpu_hp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    output logic     o_valid,
    input  logic     i_take,
    output t_in_item o_data
);

    logic     r_valid;
    t_in_item r_data;

    // The register holds while its octet waits for the parser.
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload capture on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

>>> rtl/core/gtpu_hp_parser.sv
`timescale 1ns / 1ps

module gtpu_hp_parser
    import gtpu_hp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    input  logic      i_out_free,
    output logic      o_take,
    output logic      o_emit,
    output t_out_item o_result
);

    // Parser state.
    t_phase                r_phase;
    logic [3:0]            r_fixed;
    logic [7:0]            r_flags;
    logic [7:0]            r_type;
    logic [15:0]           r_len;
    logic [31:0]           r_teid;
    logic                  r_cont_seen;
    logic [3:0]            r_pdu;
    logic [5:0]            r_flow;
    logic [9:0]            r_rem;
    logic                  r_is_cont;
    logic [1:0]            r_err;
    logic [COUNT_BITS-1:0] r_count;

    // Updated values before the end-of-packet clear.
    t_phase                u_phase;
    logic [3:0]            u_fixed;
    logic [7:0]            u_flags;
    logic [7:0]            u_type;
    logic [15:0]           u_len;
    logic [31:0]           u_teid;
    logic                  u_cont_seen;
    logic [3:0]            u_pdu;
    logic [5:0]            u_flow;
    logic [9:0]            u_rem;
    logic                  u_is_cont;
    logic [1:0]            u_err;
    logic [COUNT_BITS-1:0] u_count;

    logic [7:0]             b;
    logic                   last;
    logic                   done;
    logic                   next_end;
    logic                   clear;
    logic                   emit;
    logic [1:0]             status;
    logic [9:0]             len_x4;
    logic [HDR_BYTES_W-1:0] hdr_bytes;

    assign b    = i_data.data_byte;
    assign last = i_data.last_byte;

    // A next-type octet ends the header on end-of-chain or after an error.
    assign next_end = (b == EXT_END) || (r_err != ST_OK);
    assign len_x4   = {b, 2'b00};

    // Header octet counter, saturating; payload octets are not counted.
    assign u_count = (r_phase != PH_PAYLOAD && r_count != {COUNT_BITS{1'b1}})
                     ? r_count + 1'b1 : r_count;

    // The result shows the counter clipped or zero-extended to the field width.
    generate
        if (COUNT_BITS > HDR_BYTES_W) begin : g_clip
            assign hdr_bytes = (|u_count[COUNT_BITS-1:HDR_BYTES_W])
                               ? {HDR_BYTES_W{1'b1}} : u_count[HDR_BYTES_W-1:0];
        end else if (COUNT_BITS == HDR_BYTES_W) begin : g_same
            assign hdr_bytes = u_count;
        end else begin : g_ext
            assign hdr_bytes = {{(HDR_BYTES_W - COUNT_BITS){1'b0}}, u_count};
        end
    endgenerate

    // One parse step on the octet in the input register.
    always_comb begin
        u_phase     = r_phase;
        u_fixed     = r_fixed;
        u_flags     = r_flags;
        u_type      = r_type;
        u_len       = r_len;
        u_teid      = r_teid;
        u_cont_seen = r_cont_seen;
        u_pdu       = r_pdu;
        u_flow      = r_flow;
        u_rem       = r_rem;
        u_is_cont   = r_is_cont;
        u_err       = r_err;
        done        = 1'b0;

        unique case (r_phase)
            PH_FIXED: begin
                case (r_fixed)
                    FIX_FLAGS: begin
                        u_flags = b;
                        if ((b & VER_MASK) != VER_PT) begin
                            u_err = ST_BADVER;
                        end
                    end
                    FIX_TYPE: u_type = b;
                    FIX_LEN_HI, FIX_LEN_LO: u_len = {r_len[7:0], b};
                    FIX_TEID0, FIX_TEID1, FIX_TEID2, FIX_TEID3: begin
                        u_teid = {r_teid[23:0], b};
                    end
                    default: ;
                endcase
                if (r_fixed == FIX_TEID3 && (r_flags & OPT_MASK) == 8'h00) begin
                    done = 1'b1;
                end else if (r_fixed >= FIX_NEXT) begin
                    if (next_end) begin
                        done = 1'b1;
                    end else begin
                        u_is_cont = (b == EXT_CONT);
                        u_phase   = PH_EXTLEN;
                    end
                end else begin
                    u_fixed = r_fixed + 4'd1;
                end
            end
            PH_EXTLEN: begin
                if (b == 8'h00) begin
                    u_err   = ST_BADLEN;
                    u_phase = PH_NEXT;
                end else if (r_is_cont) begin
                    u_rem   = len_x4 - 10'd4;
                    u_phase = PH_CONT1;
                end else begin
                    u_rem   = len_x4 - 10'd2;
                    u_phase = PH_SKIP;
                end
            end
            PH_CONT1: begin
                u_pdu       = b[7:4];
                u_cont_seen = 1'b1;
                u_phase     = PH_CONT2;
            end
            PH_CONT2: begin
                u_flow  = b[5:0] & QFI_MASK[5:0];
                u_phase = (r_rem != 10'd0) ? PH_SKIP : PH_NEXT;
            end
            PH_SKIP: begin
                if (r_rem != 10'd0) begin
                    u_rem = r_rem - 10'd1;
                end
                if (u_rem == 10'd0) begin
                    u_phase = PH_NEXT;
                end
            end
            PH_NEXT: begin
                if (next_end) begin
                    done = 1'b1;
                end else begin
                    u_is_cont = (b == EXT_CONT);
                    u_phase   = PH_EXTLEN;
                end
            end
            PH_PAYLOAD: ;
            default: u_phase = PH_FIXED;
        endcase

        if (done && !last) begin
            u_phase = PH_PAYLOAD;
        end
    end

    // Result decision: header end, or a packet cut short.
    assign emit   = (r_phase != PH_PAYLOAD) && (done || last);
    assign status = done ? u_err : ST_TRUNC;
    assign clear  = last;

    assign o_emit = i_valid && emit;
    assign o_take = i_valid && (!emit || i_out_free);

    always_comb begin
        o_result.message_type      = u_type;
        o_result.length_field      = u_len;
        o_result.tunnel_id         = u_teid;
        o_result.container_present = u_cont_seen;
        o_result.pdu_type          = u_pdu;
        o_result.flow_id           = u_flow;
        o_result.header_bytes      = hdr_bytes;
        o_result.status            = status;
    end

    // State register; the last octet of a packet clears everything.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && clear)) begin
            r_phase     <= PH_FIXED;
            r_fixed     <= '0;
            r_flags     <= '0;
            r_type      <= '0;
            r_len       <= '0;
            r_teid      <= '0;
            r_cont_seen <= 1'b0;
            r_pdu       <= '0;
            r_flow      <= '0;
            r_rem       <= '0;
            r_is_cont   <= 1'b0;
            r_err       <= ST_OK;
            r_count     <= '0;
        end else if (o_take) begin
            r_phase     <= u_phase;
            r_fixed     <= u_fixed;
            r_flags     <= u_flags;
            r_type      <= u_type;
            r_len       <= u_len;
            r_teid      <= u_teid;
            r_cont_seen <= u_cont_seen;
            r_pdu       <= u_pdu;
            r_flow      <= u_flow;
            r_rem       <= u_rem;
            r_is_cont   <= u_is_cont;
            r_err       <= u_err;
            r_count     <= u_count;
        end
    end

endmodule

>>> rtl/core/gtpu_hp_out_reg.sv
`timescale 1ns / 1ps

module gtpu_hp_out_reg
    import gtpu_hp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_data,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic      r_valid;
    t_out_item r_data;

    // The register can take a new result when empty or being drained.
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Result capture.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

endmodule

>>> rtl/core/gtpu_header_parser_unit.sv
`timescale 1ns / 1ps

// GTP-U header parser.
// Input channel: one packet octet per transaction (i_in_valid, o_in_stall,
// i_in_data), header first, with last_byte set on the final octet.
// Output channel: one header result per packet (o_out_valid, i_out_stall,
// o_out_data), carrying type, length, TEID, PDU session container fields,
// the header octet count and a status.
// The result leaves on the octet that ends the header, or on the last octet
// of a packet whose header is cut short (truncated status). Payload octets
// produce no result.
// The octet that causes a result sits in the input register; the parse
// step loads the result register from it when the result register is free.
// Throughput: one octet per cycle unless the input channel stalls; the
// parse step is a single registered update of the header state between
// the two registers.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to the first header octet.
// While the receiver stalls, the pending result holds; octets that produce
// no result keep flowing, and an octet that would produce a result waits in
// the input register, stalling the input channel.
module gtpu_header_parser_unit
    import gtpu_hp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      in_valid;
    t_in_item  in_data;
    logic      take;
    logic      emit;
    logic      out_free;
    t_out_item result;

    // Input register.
    gtpu_hp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_valid (in_valid),
        .i_take  (take),
        .o_data  (in_data)
    );

    // Header state and parse step.
    gtpu_hp_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_data     (in_data),
        .i_out_free (out_free),
        .o_take     (take),
        .o_emit     (emit),
        .o_result   (result)
    );

    // Result register.
    gtpu_hp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit && take),
        .i_data  (result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

>>> sim/gtpu_header_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the GTP-U header parser, tracks the header state
// octet by octet, and compares every result transaction with the oldest
// expected header result.
module gtpu_header_checker
    import gtpu_hp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam longint unsigned HDR_MAX = (64'd1 << HDR_BYTES_W) - 1;

    // Shadow copy of the header parse state.
    t_phase                phase_q;
    logic [3:0]            fix_pos;
    logic [7:0]            flags_q;
    logic [7:0]            type_q;
    logic [15:0]           len_q;
    logic [31:0]           teid_q;
    logic                  cont_seen_q;
    logic [3:0]            pdu_q;
    logic [5:0]            qfi_q;
    logic [9:0]            skip_left;
    logic                  ext_cont_q;
    logic [1:0]            err_q;
    logic [COUNT_BITS-1:0] hdr_count;

    // Header results that have been predicted but not yet seen.
    t_out_item header_results_q[$];
    int        fails = 0;

    task automatic clear_parser();
        phase_q     = PH_FIXED;
        fix_pos     = '0;
        flags_q     = '0;
        type_q      = '0;
        len_q       = '0;
        teid_q      = '0;
        cont_seen_q = 1'b0;
        pdu_q       = '0;
        qfi_q       = '0;
        skip_left   = '0;
        ext_cont_q  = 1'b0;
        err_q       = ST_OK;
        hdr_count   = '0;
    endtask

    // Queue the header result with the fields gathered so far.
    task automatic record_header(input logic [1:0] st);
        t_out_item        r;
        longint unsigned  cnt;
        cnt                 = 64'(hdr_count);
        r.message_type      = type_q;
        r.length_field      = len_q;
        r.tunnel_id         = teid_q;
        r.container_present = cont_seen_q;
        r.pdu_type          = pdu_q;
        r.flow_id           = qfi_q & QFI_MASK[5:0];
        r.header_bytes      = (cnt > HDR_MAX) ? HDR_MAX[HDR_BYTES_W-1:0]
                                              : cnt[HDR_BYTES_W-1:0];
        r.status            = st;
        header_results_q.push_back(r);
    endtask

    // A next-type octet either closes the header or opens an extension.
    task automatic take_next_type(input logic [7:0] b, output logic ends);
        if (b == EXT_END || err_q != ST_OK) begin
            ends = 1'b1;
        end else begin
            ext_cont_q = (b == EXT_CONT);
            phase_q    = PH_EXTLEN;
            ends       = 1'b0;
        end
    endtask

    // Advance the shadow parser by one accepted octet.
    task automatic parse_octet(input t_in_item it);
        logic [7:0] b;
        logic       finished;
        b        = it.data_byte;
        finished = 1'b0;
        if (phase_q == PH_PAYLOAD) begin
            if (it.last_byte) begin
                clear_parser();
            end
        end else begin
            if (hdr_count != {COUNT_BITS{1'b1}}) begin
                hdr_count = hdr_count + 1'b1;
            end
            case (phase_q)
                PH_FIXED: begin
                    case (fix_pos)
                        FIX_FLAGS: begin
                            flags_q = b;
                            if ((b & VER_MASK) != VER_PT) begin
                                err_q = ST_BADVER;
                            end
                        end
                        FIX_TYPE: type_q = b;
                        FIX_LEN_HI, FIX_LEN_LO: len_q = {len_q[7:0], b};
                        FIX_TEID0, FIX_TEID1, FIX_TEID2, FIX_TEID3: begin
                            teid_q = {teid_q[23:0], b};
                        end
                        default: ;
                    endcase
                    if (fix_pos == FIX_TEID3 && (flags_q & OPT_MASK) == 8'h00) begin
                        finished = 1'b1;
                    end else if (fix_pos >= FIX_NEXT) begin
                        take_next_type(b, finished);
                    end else begin
                        fix_pos = fix_pos + 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    if (b == 8'h00) begin
                        err_q   = ST_BADLEN;
                        phase_q = PH_NEXT;
                    end else if (ext_cont_q) begin
                        skip_left = {b, 2'b00} - 10'd4;
                        phase_q   = PH_CONT1;
                    end else begin
                        skip_left = {b, 2'b00} - 10'd2;
                        phase_q   = PH_SKIP;
                    end
                end
                PH_CONT1: begin
                    pdu_q       = b[7:4];
                    cont_seen_q = 1'b1;
                    phase_q     = PH_CONT2;
                end
                PH_CONT2: begin
                    qfi_q   = b[5:0];
                    phase_q = (skip_left != 0) ? PH_SKIP : PH_NEXT;
                end
                PH_SKIP: begin
                    if (skip_left != 0) begin
                        skip_left = skip_left - 1'b1;
                    end
                    if (skip_left == 0) begin
                        phase_q = PH_NEXT;
                    end
                end
                PH_NEXT: take_next_type(b, finished);
                default: phase_q = PH_FIXED;
            endcase

            // Close the header, or report a packet cut short.
            if (finished) begin
                record_header(err_q);
                if (it.last_byte) begin
                    clear_parser();
                end else begin
                    phase_q = PH_PAYLOAD;
                end
            end else if (it.last_byte) begin
                record_header(ST_TRUNC);
                clear_parser();
            end
        end
    endtask

    function automatic int field_bad(input string name, input longint unsigned want,
                                     input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Follow input transactions and compare result transactions.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            clear_parser();
            header_results_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                parse_octet(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (header_results_q.size() == 0) begin
                    $error("unexpected header result: 0x%0h", got);
                    fails = fails + 1;
                end else begin
                    want  = header_results_q.pop_front();
                    fails = fails
                        + field_bad("message_type", want.message_type, got.message_type)
                        + field_bad("length_field", want.length_field, got.length_field)
                        + field_bad("tunnel_id", want.tunnel_id, got.tunnel_id)
                        + field_bad("container_present", want.container_present,
                                    got.container_present)
                        + field_bad("pdu_type", want.pdu_type, got.pdu_type)
                        + field_bad("flow_id", want.flow_id, got.flow_id)
                        + field_bad("header_bytes", want.header_bytes, got.header_bytes)
                        + field_bad("status", want.status, got.status);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= header_results_q.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

// Feeds GTP-U packets octet by octet into the header parser and lets the
// checker judge every header result.
module testbench;
    import gtpu_hp_pkg::*;

    localparam longint TIMEOUT_NS = 64'd8_000_000;
    localparam int     ITEM_COUNT = 1350;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;
    int        fail_count;
    int        pending;

    // Random idling is switched off while this is set.
    bit        calm = 1'b0;

    // Octet transactions accepted so far.
    int        octets_sent = 0;

    // Octets of the packet under construction.
    logic [7:0] octet_q[$];

    gtpu_header_parser_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    gtpu_header_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The receiver stalls at random, except in calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 15);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench failed");
        $finish;
    end

    task automatic add_fixed(input logic [7:0] flags, input logic [7:0] mtype,
                             input logic [15:0] len, input logic [31:0] teid);
        octet_q.push_back(flags);
        octet_q.push_back(mtype);
        octet_q.push_back(len[15:8]);
        octet_q.push_back(len[7:0]);
        octet_q.push_back(teid[31:24]);
        octet_q.push_back(teid[23:16]);
        octet_q.push_back(teid[15:8]);
        octet_q.push_back(teid[7:0]);
    endtask

    // Sequence number, N-PDU number and the first next-type octet.
    task automatic add_opt(input logic [7:0] first_kind);
        repeat (3) octet_q.push_back(8'($urandom));
        octet_q.push_back(first_kind);
    endtask

    // Length octet, contents, then the next-type octet. A zero length is
    // followed by the single octet that closes the header.
    task automatic add_ext(input logic [7:0] kind, input int unsigned len,
                           input logic [7:0] next_kind);
        int unsigned fill;
        fill = 0;
        octet_q.push_back(8'(len));
        if (len != 0 && kind == EXT_CONT) begin
            octet_q.push_back(8'($urandom));
            octet_q.push_back(8'($urandom));
            fill = 4 * len - 4;
        end else if (len != 0) begin
            fill = 4 * len - 2;
        end
        repeat (fill) octet_q.push_back(8'($urandom));
        octet_q.push_back(next_kind);
    endtask

    task automatic add_payload(input int n);
        repeat (n) octet_q.push_back(8'($urandom));
    endtask

    // Drop octets so that the packet ends after the first keep octets.
    task automatic cut_packet(input int keep);
        logic [7:0] dropped;
        while (octet_q.size() > keep) dropped = octet_q.pop_back();
    endtask

    // Drive one octet transaction and wait until it is taken.
    task automatic send_octet(input logic [7:0] b, input logic last);
        t_in_item it;
        it.data_byte = b;
        it.last_byte = last;
        if (!calm && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        octets_sent = octets_sent + 1;
    endtask

    task automatic send_packet();
        foreach (octet_q[k]) send_octet(octet_q[k], k == octet_q.size() - 1);
        octet_q.delete();
    endtask

    // Hold the sender until every expected header result has arrived.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_kind();
        if ($urandom_range(1) == 0) return EXT_CONT;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic int unsigned pick_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(1, 2);
        if (roll < 86) return $urandom_range(3, 4);
        if (roll < 96) return 0;
        return $urandom_range(5, 64);
    endfunction

    // Build one random packet.
    task automatic random_packet();
        logic [7:0]  flags;
        logic [7:0]  kinds[4];
        int          n_ext;
        logic [7:0]  next_kind;
        int          hdr_len;
        if ($urandom_range(99) < 8) begin
            // Noise: arbitrary octets.
            add_payload($urandom_range(1, 24));
        end else begin
            flags = {4'h3, 4'($urandom)};
            if ($urandom_range(99) < 8) flags = 8'($urandom);
            add_fixed(flags, 8'($urandom), 16'($urandom), $urandom);
            if ((flags & OPT_MASK) != 8'h00) begin
                n_ext = $urandom_range(0, 3);
                foreach (kinds[k]) kinds[k] = pick_kind();
                add_opt(n_ext == 0 ? EXT_END : kinds[0]);
                for (int k = 0; k < n_ext; k++) begin
                    next_kind = (k == n_ext - 1) ? EXT_END : kinds[k + 1];
                    add_ext(kinds[k], pick_len(), next_kind);
                end
            end
            hdr_len = octet_q.size();
            if ($urandom_range(99) < 25) begin
                add_payload(0);
            end else begin
                add_payload($urandom_range(1, 6));
            end
            // Some packets end inside their header.
            if ($urandom_range(99) < 12) begin
                hdr_len = $urandom_range(1, hdr_len - 1);
                cut_packet(hdr_len);
            end
        end
    endtask

    initial begin
        int pkt_idx;
        pkt_idx = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Plain header with all fields at their maximum, ending on the
        // last octet.
        add_fixed(8'h30, 8'hff, 16'hffff, 32'hffff_ffff);
        send_packet();
        // All-zero fields with payload.
        add_fixed(8'h30, 8'h00, 16'h0000, 32'h0000_0000);
        add_payload(3);
        send_packet();
        // All option flags and a one-word container.
        add_fixed(8'h37, 8'hff, 16'h0010, 32'h1234_5678);
        add_opt(EXT_CONT);
        add_ext(EXT_CONT, 1, EXT_END);
        add_payload(2);
        send_packet();
        // Other extension, then a two-word container.
        add_fixed(8'h34, 8'h10, 16'h0020, 32'h8000_0001);
        add_opt(8'h40);
        add_ext(8'h40, 1, EXT_CONT);
        add_ext(EXT_CONT, 2, EXT_END);
        add_payload(1);
        send_packet();
        // Wrong version without options.
        add_fixed(8'h10, 8'h01, 16'h0004, 32'h0000_00ff);
        add_payload(2);
        send_packet();
        // Wrong version with options: the header stops at the next-type octet.
        add_fixed(8'hf2, 8'h02, 16'h0008, 32'h00ff_0000);
        add_opt(EXT_CONT);
        add_ext(EXT_CONT, 1, EXT_END);
        send_packet();
        // Zero extension length.
        add_fixed(8'h31, 8'h03, 16'h0001, 32'hcafe_f00d);
        add_opt(EXT_CONT);
        add_ext(EXT_CONT, 0, 8'h55);
        add_payload(3);
        send_packet();
        // Packet of a single octet, then one cut inside a container.
        octet_q.push_back(8'h30);
        send_packet();
        add_fixed(8'h35, 8'h04, 16'h0002, 32'h5555_aaaa);
        add_opt(EXT_CONT);
        add_ext(EXT_CONT, 2, EXT_END);
        cut_packet(15);
        send_packet();
        // Long container whose skip count needs every bit of the counter.
        add_fixed(8'h36, 8'hfe, 16'h0400, 32'h7fff_ffff);
        add_opt(EXT_CONT);
        add_ext(EXT_CONT, 130, EXT_END);
        add_payload(1);
        send_packet();

        wait_drained();

        // Random packets, with one calm stretch.
        while (octets_sent < ITEM_COUNT) begin
            calm = (pkt_idx >= 4 && pkt_idx < 12);
            random_packet();
            send_packet();
            pkt_idx = pkt_idx + 1;
        end
        calm = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
